### rtl/core/sawtc_pkg.sv
package sawtc_pkg;

    localparam int NUM_WAYS_DEF    = 4;
    localparam int NUM_SETS_DEF    = 8;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int MEM_BLOCKS_DEF  = 1024;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int CNT_W   = 32;
    localparam int STAMP_W = 32;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Outcome of the way lookup and victim scan.
    typedef struct packed {
        logic       hit;
        logic [3:0] way;
    } lookup_t;

endpackage

### rtl/core/sawtc_victim.sv
// Serial tag lookup and victim choice: one way of the set is examined per cycle
// with a single tag compare and a single stamp compare.
module sawtc_victim #(
    parameter int NUM_WAYS = sawtc_pkg::NUM_WAYS_DEF,
    parameter int TAG_W    = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           way_valid,
    input  logic [TAG_W-1:0]               way_tag,
    input  logic [sawtc_pkg::STAMP_W-1:0]  way_stamp,
    input  logic [TAG_W-1:0]               req_tag,
    output logic [$clog2(NUM_WAYS+1)-1:0]  way_idx,
    output logic                           done,
    output sawtc_pkg::lookup_t             result
);
    import sawtc_pkg::*;

    localparam int IW = $clog2(NUM_WAYS + 1);

    logic [IW-1:0]      idx_reg, idx_next;
    logic               busy_reg, busy_next;
    logic               hit_reg, hit_next;
    logic               inv_reg, inv_next;
    logic [IW-1:0]      best_reg, best_next;
    logic [STAMP_W-1:0] bstamp_reg, bstamp_next;

    always_comb
    begin
        idx_next    = idx_reg;
        busy_next   = busy_reg;
        hit_next    = hit_reg;
        inv_next    = inv_reg;
        best_next   = best_reg;
        bstamp_next = bstamp_reg;
        if (start)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
            hit_next  = 1'b0;
            inv_next  = 1'b0;
            best_next = '0;
        end
        else if (busy_reg)
        begin
            if (way_valid && way_tag == req_tag && !hit_reg)
            begin
                hit_next  = 1'b1;
                best_next = idx_reg;
            end
            else if (!hit_reg && !inv_reg)
            begin
                if (!way_valid)
                begin
                    inv_next  = 1'b1;
                    best_next = idx_reg;
                end
                else if (idx_reg == '0 || way_stamp < bstamp_reg)
                begin
                    best_next   = idx_reg;
                    bstamp_next = way_stamp;
                end
            end
            idx_next = idx_reg + IW'(1);
            if (idx_reg == IW'(NUM_WAYS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            hit_reg  <= 1'b0;
            inv_reg  <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            hit_reg  <= hit_next;
            inv_reg  <= inv_next;
            best_reg <= best_next;
        end
    end

    always_ff @(posedge clk)
        bstamp_reg <= bstamp_next;

    assign way_idx    = idx_reg;
    assign done       = busy_reg && (idx_reg == IW'(NUM_WAYS - 1));
    assign result.hit = hit_next;
    assign result.way = 4'(best_next);
endmodule

### rtl/core/set_assoc_write_through_cache.sv
// Steps from acceptance to result: the serial way scan, a decision state, then for a
// read miss a block fill (one byte copied per cycle) and for every read the two cache
// read states, then the output state; a write goes from decision straight to output.
// One item at a time: the next item is accepted no earlier than the edge at which the
// result is taken; the serial way scan and the single-port block copy set the rate.
// Reset clears valid bits, set counters and the access and miss counters at once;
// tags, stamps, cached data and main memory are not cleared.
module set_assoc_write_through_cache #(
    parameter int NUM_WAYS    = sawtc_pkg::NUM_WAYS_DEF,
    parameter int NUM_SETS    = sawtc_pkg::NUM_SETS_DEF,
    parameter int BLOCK_BYTES = sawtc_pkg::BLOCK_BYTES_DEF,
    parameter int MEM_BLOCKS  = sawtc_pkg::MEM_BLOCKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [sawtc_pkg::ADDR_W-1:0]  address,
    input  logic [sawtc_pkg::DATA_W-1:0]  write_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sawtc_pkg::DATA_W-1:0]  read_data,
    output logic                          hit,
    output logic [sawtc_pkg::CNT_W-1:0]   access_total,
    output logic [sawtc_pkg::CNT_W-1:0]   miss_total
);
    import sawtc_pkg::*;

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SETB   = $clog2(NUM_SETS);
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LINES  = NUM_SETS * NUM_WAYS;
    localparam int LN_W   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int MB_W   = $clog2(MEM_BLOCKS);
    localparam int TAG_W  = (ADDR_W - OFF_W - SETB > 0) ? ADDR_W - OFF_W - SETB : 1;
    localparam int BLK_W  = ADDR_W - OFF_W;
    localparam int CB_W   = $clog2(BLOCK_BYTES + 1);
    localparam int IW     = $clog2(NUM_WAYS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_FILL = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_RD2  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [DATA_W-1:0] line_bytes [LINES*BLOCK_BYTES];
    logic [DATA_W-1:0] main_memory [MEM_BLOCKS*BLOCK_BYTES];
    logic [TAG_W-1:0]   line_tag   [LINES];
    logic [STAMP_W-1:0] line_stamp [LINES];
    logic [LINES-1:0]   line_valid_reg;
    logic [STAMP_W-1:0] set_counter_reg [NUM_SETS];

    logic              wr_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [MB_W-1:0]   mblk_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [WAY_W-1:0]  way_reg;
    logic              hit_reg;
    logic [CB_W-1:0]   cnt_reg;
    logic [DATA_W-1:0] mem_q_reg, cache_q_reg;

    logic [CNT_W-1:0]  acc_reg, miss_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              hit_out_reg, ovalid_reg;

    logic [BLK_W-1:0]  blk;
    logic              start;
    logic              scan_done;
    logic [IW-1:0]     scan_idx;
    lookup_t           lk;
    logic [LN_W-1:0]   scan_ln, cur_ln;
    logic [STAMP_W-1:0] stamp_now;

    assign blk   = address[ADDR_W-1:OFF_W];
    assign start = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || (ovalid_reg && out_stall);

    assign scan_ln = LN_W'(set_reg) * LN_W'(NUM_WAYS) + LN_W'(scan_idx);
    assign cur_ln  = LN_W'(set_reg) * LN_W'(NUM_WAYS) + LN_W'(way_reg);
    assign stamp_now = set_counter_reg[set_reg];

    sawtc_victim #(.NUM_WAYS(NUM_WAYS), .TAG_W(TAG_W)) u_victim (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .way_valid (line_valid_reg[scan_ln]),
        .way_tag   (line_tag[scan_ln]),
        .way_stamp (line_stamp[scan_ln]),
        .req_tag   (tag_reg),
        .way_idx   (scan_idx),
        .done      (scan_done),
        .result    (lk)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_SCAN;
            ST_SCAN: if (scan_done) state_next = ST_DEC;
            ST_DEC:
                if (!wr_reg && !hit_reg) state_next = ST_FILL;
                else if (!wr_reg)        state_next = ST_RD;
                else                     state_next = ST_OUT;
            ST_FILL: if (cnt_reg == CB_W'(BLOCK_BYTES)) state_next = ST_RD;
            ST_RD:   state_next = ST_RD2;
            ST_RD2:  state_next = ST_OUT;
            ST_OUT:  if (!ovalid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            line_valid_reg <= '0;
            acc_reg        <= '0;
            miss_reg       <= '0;
            ovalid_reg     <= 1'b0;
            cnt_reg        <= '0;
            for (int s = 0; s < NUM_SETS; s++)
                set_counter_reg[s] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_DEC)
            begin
                cnt_reg <= '0;
                acc_reg <= acc_reg + CNT_W'(1);
                if (!hit_reg)
                    miss_reg <= miss_reg + CNT_W'(1);
                if (!wr_reg && !hit_reg)
                    line_valid_reg[cur_ln] <= 1'b1;
                if ((wr_reg && hit_reg) || (!wr_reg && !hit_reg))
                    if (stamp_now != '1)
                        set_counter_reg[set_reg] <= stamp_now + STAMP_W'(1);
            end
            if (state_reg == ST_FILL)
                cnt_reg <= cnt_reg + CB_W'(1);
            if (state_reg == ST_OUT && state_next == ST_IDLE)
                ovalid_reg <= 1'b1;
        end
    end

    // Fill pipeline: memory read at count n, cache write of that byte at n+1.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            wr_reg    <= (req_type == REQ_WRITE);
            off_reg   <= address[OFF_W-1:0];
            set_reg   <= SET_W'(blk % NUM_SETS);
            tag_reg   <= TAG_W'(blk / NUM_SETS);
            mblk_reg  <= MB_W'(blk);
            wdata_reg <= write_data;
        end
        if (state_reg == ST_SCAN && scan_done)
        begin
            hit_reg <= lk.hit;
            way_reg <= WAY_W'(lk.way);
        end
        if (state_reg == ST_DEC)
        begin
            if (wr_reg)
            begin
                main_memory[{mblk_reg, off_reg}] <= wdata_reg;
                if (hit_reg)
                begin
                    line_bytes[{cur_ln, off_reg}] <= wdata_reg;
                    line_stamp[cur_ln] <= stamp_now;
                end
            end
            else if (!hit_reg)
            begin
                line_tag[cur_ln]   <= tag_reg;
                line_stamp[cur_ln] <= stamp_now;
            end
        end
        if (state_reg == ST_FILL)
        begin
            if (cnt_reg != CB_W'(BLOCK_BYTES))
                mem_q_reg <= main_memory[{mblk_reg, OFF_W'(cnt_reg)}];
            if (cnt_reg != '0)
                line_bytes[{cur_ln, OFF_W'(cnt_reg - CB_W'(1))}] <= mem_q_reg;
        end
        if (state_reg == ST_RD)
            cache_q_reg <= line_bytes[{cur_ln, off_reg}];
        if (state_reg == ST_RD2 || (state_reg == ST_DEC && wr_reg))
        begin
            rdata_reg   <= wr_reg ? '0 : cache_q_reg;
            hit_out_reg <= hit_reg;
        end
    end

    assign out_valid    = ovalid_reg;
    assign read_data    = rdata_reg;
    assign hit          = hit_out_reg;
    assign access_total = acc_reg;
    assign miss_total   = miss_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall) else $error("item taken while busy");
    a_acc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC) |=> (acc_reg == $past(acc_reg) + CNT_W'(1)))
        else $error("access count did not advance");
    a_miss_le: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC && hit_reg) |=> $stable(miss_reg))
        else $error("miss counted on a hit");
endmodule
